// ===== src/rtcc_pkg.sv =====
// Shared types, constants and tables for the calendar/RTC time converter.
`timescale 1ns / 1ps

package rtcc_pkg;

	// Operation codes
	typedef enum logic {
		OP_PACK   = 1'b0,
		OP_UNPACK = 1'b1
	} op_t;

	// Month classes for the summer-time rule
	typedef enum logic [1:0] {
		MC_WINTER,
		MC_SUMMER,
		MC_MARCH,
		MC_OCTOBER
	} mcls_t;

	// Time and calendar constants
	localparam logic [26:0] MS_PER_HOUR      = 27'd3600000;
	localparam logic [21:0] MS_PER_MIN       = 22'd60000;
	localparam logic [15:0] MS_PER_SEC       = 16'd1000;
	localparam logic [26:0] MS_DAY_MAX       = 27'd86399999;
	localparam logic [11:0] YEAR_BASE        = 12'd1980;
	localparam logic [12:0] ZELLER_BIAS      = 13'd400;
	localparam logic [12:0] YEARS_PER_CENT   = 13'd100;
	localparam logic [8:0]  DAYS_PER_WEEK    = 9'd7;
	localparam logic signed [6:0] DST_CUTOFF = 7'sd25;

	// Reciprocals for division by constants (value times recip, then shift)
	localparam logic [12:0] CENT_RECIP = 13'd5243;     // / 100,          shift 19
	localparam logic [20:0] HOUR_RECIP = 21'd1221680;  // / 28125 (>>7),  shift 35
	localparam logic [16:0] MIN_RECIP  = 17'd71583;    // / 1875 (>>5),   shift 27
	localparam logic [13:0] SEC_RECIP  = 14'd8389;     // / 125 (>>3),    shift 20
	localparam logic [11:0] WDAY_RECIP = 12'd2341;     // / 7,            shift 14

	// One input beat
	typedef struct packed {
		logic        op;
		logic [11:0] cal_year;
		logic [3:0]  cal_month;
		logic [4:0]  cal_day;
		logic [4:0]  cal_hour;
		logic [5:0]  cal_minute;
		logic [5:0]  cal_second;
		logic [9:0]  cal_msec;
		logic [7:0]  rtc_year_in;
		logic [26:0] rtc_ms_in;
	} in_t;

	// One result beat
	typedef struct packed {
		logic [7:0]  rtc_year_out;
		logic [26:0] rtc_ms_out;
		logic [2:0]  weekday;
		logic        summer_time;
		logic [11:0] full_year_out;
		logic [3:0]  month_out;
		logic [4:0]  day_out;
		logic [4:0]  hour_out;
		logic [5:0]  minute_out;
		logic [5:0]  second_out;
		logic [9:0]  msec_out;
	} res_t;

	// Classified command held in the queue between front and back
	typedef struct packed {
		op_t         op;
		mcls_t       mcls;
		logic [7:0]  rtc_year;
		logic [11:0] full_year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [9:0]  msec;
		logic [12:0] zy;
		logic [3:0]  zm;
		logic [26:0] rms;
	} cmd_t;

	// Month term of the Zeller sum: (13 * (m + 1)) / 5
	function automatic logic [5:0] month_term(input logic [3:0] m);
		logic [5:0] t;
		unique case (m)
			4'd0:  t = 6'd2;
			4'd1:  t = 6'd5;
			4'd2:  t = 6'd7;
			4'd3:  t = 6'd10;
			4'd4:  t = 6'd13;
			4'd5:  t = 6'd15;
			4'd6:  t = 6'd18;
			4'd7:  t = 6'd20;
			4'd8:  t = 6'd23;
			4'd9:  t = 6'd26;
			4'd10: t = 6'd28;
			4'd11: t = 6'd31;
			4'd12: t = 6'd33;
			4'd13: t = 6'd36;
			4'd14: t = 6'd39;
			default: t = 6'd41;
		endcase
		return t;
	endfunction

endpackage

// ===== src/rtcc_fifo.sv =====
// Small flip-flop queue with count-based full and empty flags.
`timescale 1ns / 1ps

module rtcc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty,
	output logic             full
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             wr_ok;
	logic             rd_ok;

	assign wr_ok   = wr_en && !full;
	assign rd_ok   = rd_en && !empty;
	assign empty   = (count_q == '0);
	assign full    = (count_q == CW'(DEPTH));
	assign rd_data = mem_q[rd_ptr_q];

	// Advance pointers and track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_ok) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (rd_ok) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({wr_ok, rd_ok})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// Store the incoming beat
	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== src/rtcc_front.sv =====
// Front end: takes input beats, classifies them and prepares queue entries.
`timescale 1ns / 1ps

module rtcc_front (
	input  logic               push,
	input  rtcc_pkg::in_t      item,
	input  logic               q_full,
	output logic               q_wr,
	output rtcc_pkg::cmd_t     q_data
);

	logic early_month;

	assign q_wr        = push && !q_full;
	assign early_month = (item.cal_month == 4'd1) || (item.cal_month == 4'd2);

	// Classify the beat and derive the fields the back end starts from
	always_comb begin
		q_data           = '0;
		q_data.op        = rtcc_pkg::op_t'(item.op);
		q_data.rtc_year  = 8'(item.cal_year - rtcc_pkg::YEAR_BASE);
		q_data.full_year = 12'(item.rtc_year_in) + rtcc_pkg::YEAR_BASE;
		q_data.month     = item.cal_month;
		q_data.day       = item.cal_day;
		q_data.hour      = item.cal_hour;
		q_data.minute    = item.cal_minute;
		q_data.second    = item.cal_second;
		q_data.msec      = item.cal_msec;

		// January and February count as months 13 and 14 of the year before
		q_data.zy = 13'(item.cal_year) + rtcc_pkg::ZELLER_BIAS - (early_month ? 13'd1 : 13'd0);
		q_data.zm = early_month ? item.cal_month + 4'd12 : item.cal_month;

		// Clamp the day count to the last millisecond of the day
		q_data.rms = (item.rtc_ms_in > rtcc_pkg::MS_DAY_MAX) ? rtcc_pkg::MS_DAY_MAX
			: item.rtc_ms_in;

		// Summer-time class of the month
		if (item.cal_month < 4'd3 || item.cal_month > 4'd10) begin
			q_data.mcls = rtcc_pkg::MC_WINTER;
		end else if (item.cal_month == 4'd3) begin
			q_data.mcls = rtcc_pkg::MC_MARCH;
		end else if (item.cal_month == 4'd10) begin
			q_data.mcls = rtcc_pkg::MC_OCTOBER;
		end else begin
			q_data.mcls = rtcc_pkg::MC_SUMMER;
		end
	end

endmodule

// ===== src/rtcc_back.sv =====
// Back end: six-stage pipeline that packs or unpacks one queued command per cycle while a result slot is free.
`timescale 1ns / 1ps

module rtcc_back #(
	parameter int RES_DEPTH = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  rtcc_pkg::cmd_t     q_data,
	output logic               q_pop,
	input  logic               res_pop,
	output logic               res_valid,
	output rtcc_pkg::res_t     res_data
);

	localparam int CW = $clog2(RES_DEPTH + 1);

	// Fields that ride along unchanged
	typedef struct packed {
		rtcc_pkg::op_t   op;
		rtcc_pkg::mcls_t mcls;
		logic [7:0]      rtc_year;
		logic [11:0]     full_year;
		logic [3:0]      month;
		logic [4:0]      day;
	} pass_t;

	logic [CW-1:0] credit_q;
	logic          admit;
	logic [5:0]    v_q;

	pass_t       pass_s1, pass_s2, pass_s3, pass_s4, pass_s5;
	logic [26:0] msh_s1;
	logic [21:0] msm_s1;
	logic [15:0] mss_s1;
	logic [9:0]  msec_s1;
	logic [12:0] zy_s1;
	logic [3:0]  zm_s1;
	logic [24:0] cp_s1;
	logic [26:0] rms_s1;
	logic [40:0] hp_s1;

	logic [26:0] ms_s2, ms_s3, ms_s4, ms_s5;
	logic [3:0]  zm_s2;
	logic [5:0]  c_s2;
	logic [6:0]  k_s2;
	logic [4:0]  hour_s2, hour_s3, hour_s4, hour_s5;
	logic [21:0] r1_s2, r1_s3;
	logic [8:0]  h_s3, h_s4;
	logic [33:0] mp_s3;
	logic [20:0] zp_s4;
	logic [5:0]  minute_s4, minute_s5;
	logic [15:0] r2_s4, r2_s5;
	logic [2:0]  zw_s5;
	logic [26:0] sp_s5;
	rtcc_pkg::res_t res_s6;

	logic [5:0]        c_w;
	logic [4:0]        hour_w;
	logic [5:0]        minute_w;
	logic [5:0]        q_w;
	logic [5:0]        second_w;
	logic [2:0]        sun_dow;
	logic signed [6:0] last_sun;
	logic              summer;
	rtcc_pkg::res_t    res_w;

	// Admit a command only while a result slot is guaranteed downstream
	assign admit = !q_empty && (credit_q < CW'(RES_DEPTH));
	assign q_pop = admit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
			v_q      <= '0;
		end else begin
			v_q <= {v_q[4:0], admit};
			case ({admit, res_pop})
				2'b10:   credit_q <= credit_q + CW'(1);
				2'b01:   credit_q <= credit_q - CW'(1);
				default: credit_q <= credit_q;
			endcase
		end
	end

	// Quotient extraction from registered products
	assign c_w      = cp_s1[24:19];
	assign hour_w   = hp_s1[39:35];
	assign minute_w = mp_s3[32:27];
	assign q_w      = zp_s4[19:14];
	assign second_w = sp_s5[25:20];

	// Sunday-based weekday and the Sunday on or before the day
	assign sun_dow  = (zw_s5 == 3'd0) ? 3'd6 : zw_s5 - 3'd1;
	assign last_sun = $signed({2'b00, pass_s5.day}) - $signed({4'b0000, sun_dow});

	always_comb begin
		unique case (pass_s5.mcls)
			rtcc_pkg::MC_WINTER:  summer = 1'b0;
			rtcc_pkg::MC_SUMMER:  summer = 1'b1;
			rtcc_pkg::MC_MARCH:   summer = (last_sun >= rtcc_pkg::DST_CUTOFF);
			rtcc_pkg::MC_OCTOBER: summer = (last_sun < rtcc_pkg::DST_CUTOFF);
			default:              summer = 1'b0;
		endcase
	end

	// Assemble the result, zero the fields the op does not use
	always_comb begin
		res_w           = '0;
		res_w.month_out = pass_s5.month;
		res_w.day_out   = pass_s5.day;
		if (pass_s5.op == rtcc_pkg::OP_PACK) begin
			res_w.rtc_year_out = pass_s5.rtc_year;
			res_w.rtc_ms_out   = ms_s5;
			res_w.weekday      = zw_s5;
			res_w.summer_time  = summer;
		end else begin
			res_w.full_year_out = pass_s5.full_year;
			res_w.hour_out      = hour_s5;
			res_w.minute_out    = minute_s5;
			res_w.second_out    = second_w;
			res_w.msec_out      = 10'(r2_s5 - 16'(second_w) * rtcc_pkg::MS_PER_SEC);
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		// Stage 1: constant products
		pass_s1 <= '{op: q_data.op, mcls: q_data.mcls, rtc_year: q_data.rtc_year,
			full_year: q_data.full_year, month: q_data.month, day: q_data.day};
		msh_s1  <= 27'(q_data.hour) * rtcc_pkg::MS_PER_HOUR;
		msm_s1  <= 22'(q_data.minute) * rtcc_pkg::MS_PER_MIN;
		mss_s1  <= 16'(q_data.second) * rtcc_pkg::MS_PER_SEC;
		msec_s1 <= q_data.msec;
		zy_s1   <= q_data.zy;
		zm_s1   <= q_data.zm;
		cp_s1   <= 25'(q_data.zy) * 25'(rtcc_pkg::CENT_RECIP);
		rms_s1  <= q_data.rms;
		hp_s1   <= 41'(q_data.rms[26:7]) * 41'(rtcc_pkg::HOUR_RECIP);

		// Stage 2: day milliseconds, century split, hours and remainder
		pass_s2 <= pass_s1;
		ms_s2   <= msh_s1 + 27'(msm_s1) + 27'(mss_s1) + 27'(msec_s1);
		zm_s2   <= zm_s1;
		c_s2    <= c_w;
		k_s2    <= 7'(zy_s1 - 13'(c_w) * rtcc_pkg::YEARS_PER_CENT);
		hour_s2 <= hour_w;
		r1_s2   <= 22'(rms_s1 - 27'(hour_w) * rtcc_pkg::MS_PER_HOUR);

		// Stage 3: Zeller sum, minute product
		pass_s3 <= pass_s2;
		ms_s3   <= ms_s2;
		h_s3    <= 9'(pass_s2.day) + 9'(rtcc_pkg::month_term(zm_s2)) + 9'(k_s2)
			+ 9'(k_s2[6:2]) + 9'(c_s2[5:2]) + 9'(c_s2) * 9'd5;
		hour_s3 <= hour_s2;
		r1_s3   <= r1_s2;
		mp_s3   <= 34'(r1_s2[21:5]) * 34'(rtcc_pkg::MIN_RECIP);

		// Stage 4: weekday product, minutes and remainder
		pass_s4   <= pass_s3;
		ms_s4     <= ms_s3;
		h_s4      <= h_s3;
		zp_s4     <= 21'(h_s3) * 21'(rtcc_pkg::WDAY_RECIP);
		hour_s4   <= hour_s3;
		minute_s4 <= minute_w;
		r2_s4     <= 16'(r1_s3 - 22'(minute_w) * rtcc_pkg::MS_PER_MIN);

		// Stage 5: weekday, second product
		pass_s5   <= pass_s4;
		ms_s5     <= ms_s4;
		zw_s5     <= 3'(h_s4 - 9'(q_w) * rtcc_pkg::DAYS_PER_WEEK);
		hour_s5   <= hour_s4;
		minute_s5 <= minute_s4;
		r2_s5     <= r2_s4;
		sp_s5     <= 27'(r2_s4[15:3]) * 27'(rtcc_pkg::SEC_RECIP);

		// Stage 6: register the assembled result
		res_s6 <= res_w;
	end

	assign res_valid = v_q[5];
	assign res_data  = res_s6;

endmodule

// ===== src/datetime_rtc_converter_unit.sv =====
// Top level of the calendar/RTC time converter: front, command queue, back, result queue.
`timescale 1ns / 1ps

// Converts calendar time to the packed RTC form (op pack: year offset from 1980,
// millisecond of the day, Zeller weekday with 0 = Saturday, EU summer-time flag for
// the whole day) and back (op unpack: full year, hours, minutes, seconds and
// milliseconds, with day counts above 23:59:59.999 clamped). Month and day pass
// through in both directions. Both sides behave as queues: an item goes in when push
// is high and full is low, a result leaves when pop is high and empty is low. The
// block takes one item every cycle while full is low; a result shows on the result ports
// after its item is written into the command queue at the accepting edge, passes
// through the six pipeline stages in the back end and is written into the result
// queue. The back end issues into its pipeline only while a result-queue slot is
// reserved for it, so the sustained rate of one item per cycle holds as long as
// RES_DEPTH covers every result from its issue into the back end until its pop.
module datetime_rtc_converter_unit #(
	parameter int CMD_DEPTH = 4,
	parameter int RES_DEPTH = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  rtcc_pkg::in_t      item,
	output logic               empty,
	input  logic               pop,
	output rtcc_pkg::res_t     result
);

	localparam int CMD_W = $bits(rtcc_pkg::cmd_t);
	localparam int RES_W = $bits(rtcc_pkg::res_t);

	logic              cmd_wr;
	rtcc_pkg::cmd_t    cmd_wr_data;
	logic [CMD_W-1:0]  cmd_rd_data;
	logic              cmd_empty;
	logic              cmd_pop;
	logic              res_valid;
	rtcc_pkg::res_t    res_wr_data;
	logic [RES_W-1:0]  res_rd_data;
	logic              res_full;
	logic              res_pop;

	assign res_pop = pop && !empty;
	assign result  = rtcc_pkg::res_t'(res_rd_data);

	// Accept and classify
	rtcc_front u_front (
		.push   (push),
		.item   (item),
		.q_full (full),
		.q_wr   (cmd_wr),
		.q_data (cmd_wr_data)
	);

	// Decouple the front from the back
	rtcc_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_wr),
		.wr_data (cmd_wr_data),
		.rd_en   (cmd_pop),
		.rd_data (cmd_rd_data),
		.empty   (cmd_empty),
		.full    (full)
	);

	// Carry out the conversion
	rtcc_back #(
		.RES_DEPTH (RES_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (cmd_empty),
		.q_data    (rtcc_pkg::cmd_t'(cmd_rd_data)),
		.q_pop     (cmd_pop),
		.res_pop   (res_pop),
		.res_valid (res_valid),
		.res_data  (res_wr_data)
	);

	// Hold finished results until taken
	rtcc_fifo #(
		.WIDTH (RES_W),
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_valid),
		.wr_data (res_wr_data),
		.rd_en   (pop),
		.rd_data (res_rd_data),
		.empty   (empty),
		.full    (res_full)
	);

	// The credit scheme must never let the pipeline write into a full result queue
	a_no_res_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_valid && res_full))
		else $error("result written into a full result queue");

	// A queued command is visible to the back end on the next cycle
	a_cmd_visible: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_wr |=> !cmd_empty)
		else $error("command queue empty after a write");

	// Weekday is a remainder of seven
	a_weekday_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.weekday != 3'd7))
		else $error("weekday out of range");

	// Unpacked time fields stay within their ranges
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.hour_out < 5'd24 && result.minute_out < 6'd60
			&& result.second_out < 6'd60 && result.msec_out < 10'd1000))
		else $error("unpacked time field out of range");

endmodule
